// ===== rtl/core/wbps_pkg.sv =====
// Package with the word types, opcode codes and sizing constants of the pattern scan core.
package wbps_pkg;

    localparam int MAX_PATTERN_DEF = 128;
    localparam int OFFSET_BITS_DEF = 32;
    localparam int MATCH_OFFSET_W = 32;
    localparam int GROUP_SIZE = 16;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_SCAN = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] byte_value;
        logic       wildcard_req;
        logic       region_end;
    } item_word_t;

    typedef struct packed {
        logic                      found;
        logic [MATCH_OFFSET_W-1:0] match_offset;
        logic                      pattern_overflow;
    } result_word_t;

    typedef struct packed {
        logic valid;
        logic wild;
        logic [7:0] value;
    } pat_entry_t;

    typedef struct packed {
        logic clear;
        logic shift_pat;
        logic shift_win;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/wbps_cell.sv =====
// One cell of the chain: a pattern entry and a window byte, both passed to the next cell.
module wbps_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  wbps_pkg::cell_ctrl_t ctrl,
    input  wbps_pkg::pat_entry_t pat_in,
    output wbps_pkg::pat_entry_t pat_out,
    input  logic [7:0]         win_in,
    output logic [7:0]         win_out,
    output logic               ok
);

    logic       valid_reg;
    logic       valid_next;
    logic       wild_reg;
    logic [7:0] value_reg;
    logic [7:0] win_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift_pat)
        begin
            valid_next = pat_in.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift_pat)
        begin
            wild_reg  <= pat_in.wild;
            value_reg <= pat_in.value;
        end
        if (ctrl.shift_win)
        begin
            win_reg <= win_in;
        end
    end

    assign pat_out.valid = valid_reg;
    assign pat_out.wild  = wild_reg;
    assign pat_out.value = value_reg;
    assign win_out       = win_reg;

    // An unused cell or a wildcard never vetoes the match.
    assign ok = !valid_reg || wild_reg || (win_reg == value_reg);

endmodule

// ===== rtl/core/wildcard_byte_pattern_scan_core.sv =====
// Top level of the wildcard byte pattern scan core: cell chain, match reduction and result register.
//
//   Channel   Payload                 Handshake
//   item      wbps_pkg::item_word_t   item_valid / item_stall
//   result    wbps_pkg::result_word_t result_valid / result_stall
//
// Clear and append words act on the cells as they are accepted; a scan word is captured
// by the cells and the first stage, and is judged after the per-cell compares pass through
// one registered AND stage over groups of cells.
// Words follow each other in back-to-back cycles while the result register is free.
// Reset clears the pattern, the overflow flag and the region state at once.
// A held result stalls the judging stage when it holds a region-end word, and the item channel stalls behind it.
module wildcard_byte_pattern_scan_core
#(
    parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  wbps_pkg::item_word_t   item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output wbps_pkg::result_word_t result
);

    localparam int CW = $clog2(MAX_PATTERN + 1);
    localparam int GROUPS = (MAX_PATTERN + wbps_pkg::GROUP_SIZE - 1) / wbps_pkg::GROUP_SIZE;
    localparam int CMPW = (OFFSET_BITS > CW) ? OFFSET_BITS : CW;
    localparam int SATW = (OFFSET_BITS > wbps_pkg::MATCH_OFFSET_W) ?
                          OFFSET_BITS : wbps_pkg::MATCH_OFFSET_W;

    wbps_pkg::cell_ctrl_t ctrl;
    wbps_pkg::pat_entry_t pat_link [MAX_PATTERN+1];
    logic [7:0]           win_link [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0] cell_ok;

    logic                   item_acc;
    logic                   scan_acc;
    logic                   full;

    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   ovf_reg;
    logic                   ovf_next;
    logic [OFFSET_BITS-1:0] pos_reg;
    logic [OFFSET_BITS-1:0] pos_next;

    logic                   sat;
    logic [OFFSET_BITS-1:0] seen;
    logic [CMPW-1:0]        seen_ext;
    logic [CMPW-1:0]        cnt_ext;
    logic                   elig;
    logic [OFFSET_BITS-1:0] start_off;

    logic                   p1_valid_reg;
    logic                   p1_valid_next;
    logic                   p1_elig_reg;
    logic [OFFSET_BITS-1:0] p1_off_reg;
    logic                   p1_last_reg;
    logic                   p1_ovf_reg;

    logic                   p2_valid_reg;
    logic                   p2_valid_next;
    logic                   p2_elig_reg;
    logic [OFFSET_BITS-1:0] p2_off_reg;
    logic                   p2_last_reg;
    logic                   p2_ovf_reg;
    logic [GROUPS-1:0]      grp_reg;
    logic [GROUPS-1:0]      grp_next;

    logic                   p2_block;
    logic                   p2_free;
    logic                   p1_move;
    logic                   decide;

    logic                   hit_reg;
    logic                   hit_next;
    logic [OFFSET_BITS-1:0] first_reg;
    logic [OFFSET_BITS-1:0] first_next;
    logic                   hit_now;
    logic [OFFSET_BITS-1:0] off_now;
    logic [SATW-1:0]        off_sat_ext;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    wbps_pkg::result_word_t out_reg;
    wbps_pkg::result_word_t out_next;
    logic                   out_load;

    // Handshake and stage movement.
    assign p2_block   = p2_last_reg && out_valid_reg && result_stall;
    assign p2_free    = !p2_valid_reg || !p2_block;
    assign p1_move    = p1_valid_reg && p2_free;
    assign item_stall = p1_valid_reg && !p2_free;
    assign item_acc   = item_valid && !item_stall;
    assign scan_acc   = item_acc && (item.opcode == wbps_pkg::OP_SCAN);
    assign decide     = p2_valid_reg && !p2_block;
    assign out_load   = decide && p2_last_reg;

    assign full = (count_reg == CW'(MAX_PATTERN));

    always_comb
    begin
        ctrl.clear     = item_acc && (item.opcode == wbps_pkg::OP_CLEAR);
        ctrl.shift_pat = item_acc && (item.opcode == wbps_pkg::OP_APPEND) && !full;
        ctrl.shift_win = scan_acc;
    end

    // The newest entry and the newest byte enter at cell zero.
    assign pat_link[0].valid = 1'b1;
    assign pat_link[0].wild  = item.wildcard_req;
    assign pat_link[0].value = item.byte_value;
    assign win_link[0]       = item.byte_value;

    generate
        for (genvar k = 0; k < MAX_PATTERN; k++)
        begin : g_cell
            wbps_cell u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl),
                .pat_in  (pat_link[k]),
                .pat_out (pat_link[k+1]),
                .win_in  (win_link[k]),
                .win_out (win_link[k+1]),
                .ok      (cell_ok[k])
            );
        end
    endgenerate

    // Pattern count, overflow flag and region position.
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (ctrl.clear)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (ctrl.shift_pat)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (item_acc && (item.opcode == wbps_pkg::OP_APPEND))
        begin
            ovf_next = 1'b1;
        end
    end

    always_comb
    begin
        sat       = (pos_reg == {OFFSET_BITS{1'b1}});
        seen      = sat ? pos_reg : pos_reg + OFFSET_BITS'(1);
        seen_ext  = CMPW'(seen);
        cnt_ext   = CMPW'(count_reg);
        elig      = (count_reg != '0) && (sat || (seen_ext >= cnt_ext));
        start_off = sat ? {OFFSET_BITS{1'b1}} : OFFSET_BITS'(seen_ext - cnt_ext);
        pos_next  = pos_reg;
        if (scan_acc)
        begin
            pos_next = item.region_end ? '0 : seen;
        end
    end

    // Registered AND over groups of cells.
    always_comb
    begin
        grp_next = '1;
        for (int g = 0; g < GROUPS; g++)
        begin
            for (int i = 0; i < wbps_pkg::GROUP_SIZE; i++)
            begin
                if (g * wbps_pkg::GROUP_SIZE + i < MAX_PATTERN)
                begin
                    grp_next[g] = grp_next[g] & cell_ok[g * wbps_pkg::GROUP_SIZE + i];
                end
            end
        end
    end

    always_comb
    begin
        p1_valid_next = p1_valid_reg && !p2_free;
        if (scan_acc)
        begin
            p1_valid_next = 1'b1;
        end
        p2_valid_next = p2_free ? p1_valid_reg : p2_valid_reg;
    end

    // Decision on the first hit and the result word.
    always_comb
    begin
        hit_now     = hit_reg || (p2_elig_reg && (&grp_reg));
        off_now     = hit_reg ? first_reg : p2_off_reg;
        off_sat_ext = SATW'(off_now);
        hit_next    = hit_reg;
        first_next  = first_reg;
        out_next    = out_reg;
        if (decide)
        begin
            if (p2_last_reg)
            begin
                hit_next   = 1'b0;
                first_next = '0;
            end
            else
            begin
                hit_next   = hit_now;
                first_next = off_now;
            end
        end
        if (out_load)
        begin
            out_next.found = hit_now;
            if (!hit_now)
            begin
                out_next.match_offset = '0;
            end
            else if (off_sat_ext > SATW'({wbps_pkg::MATCH_OFFSET_W{1'b1}}))
            begin
                out_next.match_offset = '1;
            end
            else
            begin
                out_next.match_offset = wbps_pkg::MATCH_OFFSET_W'(off_now);
            end
            out_next.pattern_overflow = p2_ovf_reg;
        end
        out_valid_next = out_load || (out_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            pos_reg       <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            first_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            pos_reg       <= pos_next;
            p1_valid_reg  <= p1_valid_next;
            p2_valid_reg  <= p2_valid_next;
            hit_reg       <= hit_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_acc)
        begin
            p1_elig_reg <= elig;
            p1_off_reg  <= start_off;
            p1_last_reg <= item.region_end;
            p1_ovf_reg  <= ovf_reg;
        end
        if (p1_move)
        begin
            p2_elig_reg <= p1_elig_reg;
            p2_off_reg  <= p1_off_reg;
            p2_last_reg <= p1_last_reg;
            p2_ovf_reg  <= p1_ovf_reg;
            grp_reg     <= grp_next;
        end
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== tb/wildcard_byte_pattern_scan_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the wildcard byte pattern scan core, with its own scan predictor.
module wildcard_byte_pattern_scan_core_tb;

    localparam int PAT_DEPTH = wbps_pkg::MAX_PATTERN_DEF;
    localparam longint unsigned POS_LIMIT = (64'd1 << wbps_pkg::OFFSET_BITS_DEF) - 64'd1;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_PCT = 19;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_WORDS = 1100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    wbps_pkg::item_word_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    wbps_pkg::result_word_t result;

    bit steady = 1'b0;
    int cycle_count = 0;
    int words_sent = 0;
    int reports_seen = 0;
    int reports_found = 0;
    int reports_overflow = 0;
    int mismatches = 0;

    bit [7:0] pat_value [PAT_DEPTH];
    bit pat_wild [PAT_DEPTH];
    int unsigned pat_len = 0;
    bit pat_overflow = 1'b0;
    bit [7:0] recent [PAT_DEPTH];
    longint unsigned region_pos = 0;
    bit hit_seen = 1'b0;
    longint unsigned hit_offset = 0;
    wbps_pkg::result_word_t expected_reports [$];

    wildcard_byte_pattern_scan_core i_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    function automatic wbps_pkg::item_word_t make_word(logic [1:0] op, logic [7:0] val,
                                                       logic wild, logic last);
        wbps_pkg::item_word_t w;
        w.opcode = op;
        w.byte_value = val;
        w.wildcard_req = wild;
        w.region_end = last;
        return w;
    endfunction

    function automatic bit window_hit();
        if (pat_len == 0)
            return 1'b0;
        for (int j = 0; j < pat_len; j++)
        begin
            if (!pat_wild[j] && recent[pat_len - 1 - j] != pat_value[j])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_scan_word(wbps_pkg::item_word_t w);
        bit sat;
        longint unsigned seen;
        wbps_pkg::result_word_t r;
        case (w.opcode)
            wbps_pkg::OP_CLEAR:
            begin
                pat_len = 0;
                pat_overflow = 1'b0;
            end
            wbps_pkg::OP_APPEND:
            begin
                if (pat_len < PAT_DEPTH)
                begin
                    pat_value[pat_len] = w.byte_value;
                    pat_wild[pat_len] = w.wildcard_req;
                    pat_len++;
                end
                else
                    pat_overflow = 1'b1;
            end
            wbps_pkg::OP_SCAN:
            begin
                for (int k = PAT_DEPTH - 1; k > 0; k--)
                    recent[k] = recent[k - 1];
                recent[0] = w.byte_value;
                sat = region_pos >= POS_LIMIT;
                seen = sat ? POS_LIMIT : region_pos + 1;
                if (!hit_seen && pat_len != 0 && (sat || seen >= pat_len) && window_hit())
                begin
                    hit_seen = 1'b1;
                    hit_offset = sat ? POS_LIMIT : seen - pat_len;
                end
                region_pos = seen;
                if (w.region_end)
                begin
                    r.found = hit_seen;
                    if (!hit_seen)
                        r.match_offset = '0;
                    else if (hit_offset > 64'hFFFF_FFFF)
                        r.match_offset = '1;
                    else
                        r.match_offset = hit_offset[wbps_pkg::MATCH_OFFSET_W-1:0];
                    r.pattern_overflow = pat_overflow;
                    expected_reports.insert(expected_reports.size(), r);
                    region_pos = 0;
                    hit_seen = 1'b0;
                    hit_offset = 0;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic logic [7:0] pick_byte(bit narrow);
        if (narrow)
            return {4{2'($urandom_range(3))}};
        return 8'($urandom);
    endfunction

    always @(posedge clk)
    begin
        wbps_pkg::result_word_t want;
        if (rst_n && result_valid === 1'b1 && result_stall == 1'b0)
        begin
            if (expected_reports.size() == 0)
            begin
                $error("Result word arrived with no expectation pending.");
                mismatches++;
            end
            else
            begin
                want = expected_reports.pop_front();
                reports_seen++;
                if (want.found)
                    reports_found++;
                if (want.pattern_overflow)
                    reports_overflow++;
                if (result.found !== want.found)
                begin
                    $error("found: expected %0d, actual %0d", want.found, result.found);
                    mismatches++;
                end
                if (result.match_offset !== want.match_offset)
                begin
                    $error("match_offset: expected %0d, actual %0d", want.match_offset,
                           result.match_offset);
                    mismatches++;
                end
                if (result.pattern_overflow !== want.pattern_overflow)
                begin
                    $error("pattern_overflow: expected %0d, actual %0d",
                           want.pattern_overflow, result.pattern_overflow);
                    mismatches++;
                end
            end
        end
        result_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end

    task automatic send_word(input wbps_pkg::item_word_t w);
        if (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= w;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predict_scan_word(w);
        if (w.opcode != OP_UNUSED)
            words_sent++;
    endtask

    task automatic drain_reports();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_reports.size() != 0);
    endtask

    task automatic scan_byte(input logic [7:0] val, input logic last);
        send_word(make_word(wbps_pkg::OP_SCAN, val, 1'($urandom_range(1)), last));
    endtask

    task automatic test_directed();
        scan_byte(8'hFF, 1'b1);
        send_word(make_word(OP_UNUSED, 8'h5A, 1'b1, 1'b1));
        send_word(make_word(wbps_pkg::OP_APPEND, 8'h00, 1'b0, 1'b1));
        send_word(make_word(wbps_pkg::OP_APPEND, 8'hFF, 1'b1, 1'b0));
        send_word(make_word(wbps_pkg::OP_APPEND, 8'hFF, 1'b0, 1'b1));
        scan_byte(8'h11, 1'b0);
        scan_byte(8'h00, 1'b0);
        scan_byte(8'h77, 1'b0);
        scan_byte(8'hFF, 1'b1);
        scan_byte(8'h00, 1'b0);
        scan_byte(8'hFF, 1'b1);
        scan_byte(8'h00, 1'b0);
        send_word(make_word(wbps_pkg::OP_CLEAR, 8'hAA, 1'b1, 1'b1));
        send_word(make_word(wbps_pkg::OP_APPEND, 8'hAB, 1'b0, 1'b0));
        scan_byte(8'hAB, 1'b1);
        scan_byte(8'hAB, 1'b0);
        send_word(make_word(wbps_pkg::OP_APPEND, 8'hCD, 1'b0, 1'b1));
        scan_byte(8'h00, 1'b1);
        drain_reports();
    endtask

    task automatic test_full_pattern();
        bit [7:0] vals [PAT_DEPTH];
        bit wilds [PAT_DEPTH];
        send_word(make_word(wbps_pkg::OP_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom)));
        for (int i = 0; i < PAT_DEPTH; i++)
        begin
            vals[i] = 8'($urandom);
            wilds[i] = $urandom_range(9) == 0;
            send_word(make_word(wbps_pkg::OP_APPEND, vals[i], wilds[i], 1'($urandom)));
        end
        repeat (2)
            send_word(make_word(wbps_pkg::OP_APPEND, 8'($urandom), 1'($urandom),
                                1'($urandom)));
        repeat (5)
            scan_byte(8'($urandom), 1'b0);
        for (int i = 0; i < PAT_DEPTH; i++)
            scan_byte(wilds[i] ? 8'($urandom) : vals[i], 1'b0);
        scan_byte(8'($urandom), 1'b1);
        for (int i = 0; i < PAT_DEPTH - 1; i++)
            scan_byte(vals[i], i == PAT_DEPTH - 2);
        send_word(make_word(wbps_pkg::OP_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom)));
        scan_byte(8'($urandom), 1'b1);
        drain_reports();
    endtask

    task automatic test_random();
        logic [7:0] region [$];
        int start_words;
        int done_words;
        int n_pat;
        int n_reg;
        int at;
        int pick;
        bit narrow;
        bit paused;
        start_words = words_sent;
        paused = 1'b0;
        done_words = 0;
        while (done_words < RANDOM_WORDS)
        begin
            steady = done_words >= 500 && done_words < 800;
            if (!paused && done_words >= 1000)
            begin
                drain_reports();
                paused = 1'b1;
            end
            if ($urandom_range(99) < 20)
                send_word(make_word(2'($urandom_range(3)), 8'($urandom), 1'($urandom),
                                    1'($urandom)));
            else
            begin
                narrow = $urandom_range(99) < 70;
                if ($urandom_range(99) < 75)
                    send_word(make_word(wbps_pkg::OP_CLEAR, 8'($urandom), 1'($urandom),
                                        1'($urandom)));
                pick = $urandom_range(99);
                if (pick < 85)
                    n_pat = $urandom_range(1, 6);
                else if (pick < 95)
                    n_pat = $urandom_range(7, 40);
                else
                    n_pat = $urandom_range(120, 134);
                repeat (n_pat)
                    send_word(make_word(wbps_pkg::OP_APPEND, pick_byte(narrow),
                                        $urandom_range(99) < 15, 1'($urandom)));
                repeat ($urandom_range(1, 3))
                begin
                    n_reg = $urandom_range(99) < 80 ? $urandom_range(1, 24)
                                                    : $urandom_range(25, 180);
                    region.delete();
                    repeat (n_reg)
                        region.insert(region.size(), pick_byte(narrow));
                    if (pat_len != 0 && pat_len <= n_reg && $urandom_range(99) < 60)
                    begin
                        at = $urandom_range(n_reg - pat_len);
                        for (int j = 0; j < pat_len; j++)
                        begin
                            if (!pat_wild[j])
                                region[at + j] = pat_value[j];
                        end
                    end
                    for (int k = 0; k < n_reg; k++)
                    begin
                        if ($urandom_range(99) < 3)
                            send_word(make_word(2'($urandom_range(3)) & ~wbps_pkg::OP_SCAN,
                                                pick_byte(narrow), 1'($urandom),
                                                1'($urandom)));
                        scan_byte(region[k], k == n_reg - 1);
                    end
                end
            end
            done_words = words_sent - start_words;
        end
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_pattern();
        test_random();
        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d words and checked %0d region reports, %0d with a hit, %0d %s",
                 words_sent, reports_seen, reports_found, reports_overflow,
                 "with overflow.");
        $display("Covered empty, full and overflowing patterns, wildcards, %s",
                 "short regions and edits mid-region.");
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/wbps_pkg.sv
rtl/core/wbps_cell.sv
rtl/core/wildcard_byte_pattern_scan_core.sv
tb/wildcard_byte_pattern_scan_core_tb.sv
